// ===== hw/rtl/afu_pkg.sv =====
// Shared constants, codes and table-building helpers for the activation unit
`timescale 1ns / 1ps

package afu_pkg;

  // default sizes
  localparam int DATA_WIDTH_DEFAULT   = 16;
  localparam int TABLE_POINTS_DEFAULT = 256;

  // configuration port
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 16;
  localparam int MODE_W      = 3;
  localparam int SLOPE_W     = 16;

  localparam logic [CFG_INDEX_W-1:0] REG_MODE       = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_LEAK_SLOPE = 1'd1;

  localparam logic [MODE_W-1:0]  MODE_RESET       = 3'd0;
  localparam logic [SLOPE_W-1:0] LEAK_SLOPE_RESET = 16'd655;

  // activation modes
  localparam logic [MODE_W-1:0] MODE_RELU          = 3'd0;
  localparam logic [MODE_W-1:0] MODE_RELU_DERIV    = 3'd1;
  localparam logic [MODE_W-1:0] MODE_SIGMOID       = 3'd2;
  localparam logic [MODE_W-1:0] MODE_SIGMOID_DERIV = 3'd3;
  localparam logic [MODE_W-1:0] MODE_TANH          = 3'd4;
  localparam logic [MODE_W-1:0] MODE_TANH_DERIV    = 3'd5;
  localparam logic [MODE_W-1:0] MODE_LEAKY         = 3'd6;
  localparam logic [MODE_W-1:0] MODE_LEAKY_DERIV   = 3'd7;

  // sigmoid table entries are unsigned Q0.30
  localparam int          TAB_W   = 31;
  localparam logic [63:0] Q30_ONE = 64'd1 << 30;

  // restoring long division, used only while building the table
  function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] rem;
    logic [63:0] quo;
    rem = '0;
    quo = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[62:0], num[i]};
      if (rem >= den) begin
        rem    = rem - den;
        quo[i] = 1'b1;
      end
    end
    return quo;
  endfunction

  // exp(-y) for y in Q4.31, 0 <= y <= 8: series on y/16, then squared four times
  function automatic logic [63:0] exp_neg_q31(input logic [63:0] y);
    logic [63:0]        a;
    logic signed [63:0] sum;
    logic [63:0]        term;
    logic [63:0]        r;
    a    = y >> 4;
    sum  = 64'sd1 <<< 31;
    term = 64'd1 << 31;
    for (int k = 1; k <= 14; k++) begin
      term = udiv64((term * a) >> 31, 64'(k));
      if (k % 2 == 1) begin
        sum = sum - $signed(term);
      end else begin
        sum = sum + $signed(term);
      end
    end
    r = $unsigned(sum);
    for (int k = 0; k < 4; k++) begin
      r = (r * r + (64'd1 << 30)) >> 31;
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/activation_function_unit_top.sv =====
// Elementwise activation unit: table-based sigmoid/tanh, relu and leaky relu, and their derivatives
// Throughput: one item per cycle while result_stall is low; each of the 7 register stages
// has its own valid bit and stalls only when it is full and the stage after it cannot take
// its item. The sigmoid table is a constant ROM with a registered read in stage 2.
// Reset (rst, synchronous) empties the pipeline and sets mode to relu and slope to 655.
`timescale 1ns / 1ps

module activation_function_unit_top #(
  parameter int DATA_WIDTH   = afu_pkg::DATA_WIDTH_DEFAULT,
  parameter int TABLE_POINTS = afu_pkg::TABLE_POINTS_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  // configuration writes
  input  logic                                cfg_write,
  input  logic [afu_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [afu_pkg::CFG_DATA_W-1:0]      cfg_data,
  // input channel
  input  logic                                sample_valid,
  output logic                                sample_stall,
  input  logic signed [DATA_WIDTH-1:0]        sample_in,
  input  logic                                last_in,
  // output channel
  output logic                                result_valid,
  input  logic                                result_stall,
  output logic signed [DATA_WIDTH-1:0]        sample_out,
  output logic                                last_out
);

  import afu_pkg::*;

  localparam int W    = DATA_WIDTH;
  localparam int F    = W - 4;
  localparam int IW   = $clog2(TABLE_POINTS + 1);
  localparam int TW   = TAB_W;
  localparam int MW   = (W > 31) ? W : 31;
  localparam int PW   = 2 * MW;
  localparam int RW   = W + 2;
  localparam int SH   = 30 - F;
  localparam int HALF = 1 << (SH - 1);
  localparam int NSTG = 7;

  localparam int LK_UP  = (F >= 16) ? F - 16 : 0;
  localparam int LK_DN  = (F < 16) ? 16 - F : 0;
  localparam int LK_RND = (LK_DN > 0) ? (1 << (LK_DN - 1)) : 0;

  localparam logic [W+1:0]        OFF_BIAS = (W + 2)'(1) << (W - 1);
  localparam logic signed [RW-1:0] ONE     = RW'(1) << F;
  localparam logic signed [RW-1:0] SAT_HI  = (RW'(1) << (W - 1)) - RW'(1);
  localparam logic signed [RW-1:0] SAT_LO  = -(RW'(1) << (W - 1));

  typedef logic [TW-1:0] tab_t [TABLE_POINTS+1];

  // samples of 1/(1+exp(-x)) on the grid -8 + 16*k/TABLE_POINTS, forced monotonic
  function automatic tab_t build_table();
    tab_t               t;
    logic [63:0]        xu;
    logic signed [63:0] xq;
    logic [63:0]        y;
    logic [63:0]        e;
    logic [63:0]        den;
    logic [63:0]        num;
    logic [63:0]        q;
    for (int k = 0; k <= TABLE_POINTS; k++) begin
      xu  = udiv64(64'(k) << 35, 64'(TABLE_POINTS));
      xq  = $signed(xu) - (64'sd1 <<< 34);
      y   = (xq < 0) ? $unsigned(-xq) : $unsigned(xq);
      e   = exp_neg_q31(y);
      den = (64'd1 << 31) + e;
      num = (xq >= 0) ? (64'd1 << 31) : e;
      q   = udiv64((num << 30) + (den >> 1), den);
      t[k] = TW'(q);
      if (k > 0) begin
        if (t[k] < t[k-1]) begin
          t[k] = t[k-1];
        end
      end
    end
    return t;
  endfunction

  localparam tab_t SIG_TABLE = build_table();

  // round a nonnegative Q0.30 value half up to the sample format
  function automatic logic signed [RW-1:0] to_sample(input logic [32:0] v);
    logic [33:0] acc;
    acc = {1'b0, v} + 34'(HALF);
    return RW'(acc >> SH);
  endfunction

  // configuration registers
  logic [MODE_W-1:0]  mode;
  logic [SLOPE_W-1:0] leak_slope;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= MODE_RESET;
      leak_slope <= LEAK_SLOPE_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_MODE:       mode       <= cfg_data[MODE_W-1:0];
        REG_LEAK_SLOPE: leak_slope <= cfg_data[SLOPE_W-1:0];
        default:        ;
      endcase
    end
  end

  // per-stage valid bits and advance chain
  logic [NSTG:1] vld;
  logic [NSTG:1] adv;

  always_comb begin
    adv[NSTG] = !vld[NSTG] || !result_stall;
    for (int k = NSTG - 1; k >= 1; k--) begin
      adv[k] = !vld[k] || adv[k+1];
    end
  end

  assign sample_stall = !adv[1];
  assign result_valid = vld[NSTG];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv[1]) begin
        vld[1] <= sample_valid;
      end
      for (int k = 2; k <= NSTG; k++) begin
        if (adv[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  // stage 1: table argument, range check and grid position
  logic signed [W:0] z;
  logic [W+1:0]      off;
  logic [W+IW-1:0]   pos;

  always_comb begin
    if (mode inside {MODE_TANH, MODE_TANH_DERIV}) begin
      z = {sample_in, 1'b0};
    end else begin
      z = {sample_in[W-1], sample_in};
    end
    off = {z[W], z} + OFF_BIAS;
    pos = {{IW{1'b0}}, off[W-1:0]} * (W + IW)'(TABLE_POINTS);
  end

  logic signed [W-1:0] s1_x;
  logic                s1_last;
  logic [IW-1:0]       s1_idx;
  logic [W-1:0]        s1_fr;
  logic                s1_below;
  logic                s1_above;

  always_ff @(posedge clk) begin
    if (adv[1] && sample_valid) begin
      s1_x     <= sample_in;
      s1_last  <= last_in;
      s1_idx   <= pos[W+IW-1:W];
      s1_fr    <= pos[W-1:0];
      s1_below <= off[W+1];
      s1_above <= !off[W+1] && off[W];
    end
  end

  // stage 2: registered table read of both neighbors
  logic signed [W-1:0] s2_x;
  logic                s2_last;
  logic [W-1:0]        s2_fr;
  logic                s2_below;
  logic                s2_above;
  logic [TW-1:0]       s2_lo;
  logic [TW-1:0]       s2_hi;

  always_ff @(posedge clk) begin
    if (adv[2] && vld[1]) begin
      s2_x     <= s1_x;
      s2_last  <= s1_last;
      s2_fr    <= s1_fr;
      s2_below <= s1_below;
      s2_above <= s1_above;
      s2_lo    <= SIG_TABLE[s1_idx];
      s2_hi    <= SIG_TABLE[s1_idx + IW'(1)];
    end
  end

  // stage 3: interpolation step times fraction
  logic [TW-1:0]   diff;
  logic [TW+W-1:0] interp;

  always_comb begin
    diff   = s2_hi - s2_lo;
    interp = (TW + W)'(diff) * (TW + W)'(s2_fr);
  end

  logic signed [W-1:0] s3_x;
  logic                s3_last;
  logic                s3_below;
  logic                s3_above;
  logic [TW-1:0]       s3_lo;
  logic [TW-1:0]       s3_step;

  always_ff @(posedge clk) begin
    if (adv[3] && vld[2]) begin
      s3_x     <= s2_x;
      s3_last  <= s2_last;
      s3_below <= s2_below;
      s3_above <= s2_above;
      s3_lo    <= s2_lo;
      s3_step  <= interp[TW+W-1:W];
    end
  end

  // stage 4: sigmoid value in Q0.30, clamped to the table ends outside the range
  logic signed [W-1:0] s4_x;
  logic                s4_last;
  logic [TW-1:0]       s4_s;

  always_ff @(posedge clk) begin
    if (adv[4] && vld[3]) begin
      s4_x    <= s3_x;
      s4_last <= s3_last;
      if (s3_below) begin
        s4_s <= SIG_TABLE[0];
      end else if (s3_above) begin
        s4_s <= SIG_TABLE[TABLE_POINTS];
      end else begin
        s4_s <= s3_lo + s3_step;
      end
    end
  end

  // stage 5: multiplier operands and the rounded sigmoid/tanh results
  logic signed [TW+1:0] t_val;
  logic [TW-1:0]        t_abs;
  logic [W:0]           neg_x;
  logic [MW-1:0]        opa;
  logic [MW-1:0]        opb;

  always_comb begin
    t_val = $signed({1'b0, s4_s, 1'b0}) - $signed((TW + 2)'(Q30_ONE));
    t_abs = (t_val < 0) ? TW'(-t_val) : TW'(t_val);
    neg_x = -{s4_x[W-1], s4_x};
    case (mode)
      MODE_SIGMOID_DERIV: begin
        opa = MW'(s4_s);
        opb = MW'(TW'(Q30_ONE) - s4_s);
      end
      MODE_TANH_DERIV: begin
        opa = MW'(t_abs);
        opb = MW'(t_abs);
      end
      MODE_LEAKY: begin
        opa = MW'(neg_x[W-1:0]);
        opb = MW'(leak_slope);
      end
      default: begin
        opa = '0;
        opb = '0;
      end
    endcase
  end

  logic signed [W-1:0]  s5_x;
  logic                 s5_last;
  logic [MW-1:0]        s5_opa;
  logic [MW-1:0]        s5_opb;
  logic signed [RW-1:0] s5_sig;
  logic signed [RW-1:0] s5_tanh;

  always_ff @(posedge clk) begin
    if (adv[5] && vld[4]) begin
      s5_x    <= s4_x;
      s5_last <= s4_last;
      s5_opa  <= opa;
      s5_opb  <= opb;
      s5_sig  <= to_sample({2'b00, s4_s});
      s5_tanh <= to_sample({1'b0, s4_s, 1'b0}) - ONE;
    end
  end

  // stage 6: shared multiplier
  logic signed [W-1:0]  s6_x;
  logic                 s6_last;
  logic [PW-1:0]        s6_prod;
  logic signed [RW-1:0] s6_sig;
  logic signed [RW-1:0] s6_tanh;

  always_ff @(posedge clk) begin
    if (adv[6] && vld[5]) begin
      s6_x    <= s5_x;
      s6_last <= s5_last;
      s6_prod <= PW'(s5_opa) * PW'(s5_opb);
      s6_sig  <= s5_sig;
      s6_tanh <= s5_tanh;
    end
  end

  // stage 7: mode select, saturation and output register
  logic [PW-1:0]        p_sh;
  logic [32:0]          m_cl;
  logic [PW-1:0]        lk_mag;
  logic signed [RW-1:0] lk_pos;
  logic [47:0]          leak_t;
  logic signed [RW-1:0] leak_d;
  logic                 x_pos;
  logic signed [RW-1:0] x_ext;
  logic signed [RW-1:0] res;
  logic signed [RW-1:0] res_sat;

  always_comb begin
    p_sh   = s6_prod >> 30;
    m_cl   = (p_sh > PW'(Q30_ONE)) ? 33'(Q30_ONE) : 33'(p_sh);
    lk_mag = (s6_prod + PW'(1 << 15)) >> 16;
    lk_pos = RW'(lk_mag);
    if (F >= 16) begin
      leak_t = {32'd0, leak_slope} << LK_UP;
    end else begin
      leak_t = ({32'd0, leak_slope} + 48'(LK_RND)) >> LK_DN;
    end
    leak_d = RW'(leak_t);
    x_pos  = !s6_x[W-1] && (s6_x != '0);
    x_ext  = {{2{s6_x[W-1]}}, s6_x};
    case (mode)
      MODE_RELU:          res = x_pos ? x_ext : '0;
      MODE_RELU_DERIV:    res = x_pos ? ONE : '0;
      MODE_SIGMOID:       res = s6_sig;
      MODE_SIGMOID_DERIV: res = to_sample(33'(p_sh));
      MODE_TANH:          res = s6_tanh;
      MODE_TANH_DERIV:    res = to_sample(33'(Q30_ONE) - m_cl);
      MODE_LEAKY:         res = x_pos ? x_ext : -lk_pos;
      MODE_LEAKY_DERIV:   res = x_pos ? ONE : leak_d;
      default:            res = '0;
    endcase
    if (res > SAT_HI) begin
      res_sat = SAT_HI;
    end else if (res < SAT_LO) begin
      res_sat = SAT_LO;
    end else begin
      res_sat = res;
    end
  end

  always_ff @(posedge clk) begin
    if (adv[7] && vld[6]) begin
      sample_out <= res_sat[W-1:0];
      last_out   <= s6_last;
    end
  end

endmodule

// ===== tb/afu_result_checker.sv =====
// Result checker for the activation unit: predicts each result and compares it
`timescale 1ns / 1ps

module afu_result_checker #(
  parameter int DW = afu_pkg::DATA_WIDTH_DEFAULT,
  parameter int TP = afu_pkg::TABLE_POINTS_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [afu_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [afu_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            sample_valid,
  input  logic                            sample_stall,
  input  logic signed [DW-1:0]            sample_in,
  input  logic                            last_in,
  input  logic                            result_valid,
  input  logic                            result_stall,
  input  logic signed [DW-1:0]            sample_out,
  input  logic                            last_out,
  output int                              mismatches,
  output int                              open_count
);

  import afu_pkg::*;

  localparam int    FRAC     = DW - 4;
  localparam longint SAT_MAX = (longint'(1) << (DW - 1)) - 1;
  localparam longint SAT_MIN = -(longint'(1) << (DW - 1));

  typedef struct packed {
    logic signed [DW-1:0] value;
    logic                 is_last;
  } afu_result_t;

  // sigmoid samples on the grid -8 + 16*k/TP, unsigned Q0.30
  logic [63:0] sigmoid_samples [0:TP];

  logic [MODE_W-1:0]  active_mode;
  logic [SLOPE_W-1:0] active_slope;

  afu_result_t expected_results [$];
  afu_result_t want;

  // build the sigmoid samples with integer math only
  initial begin
    longint      xq;
    longint      series;
    logic [63:0] mag, arg, term, e, den, num;
    for (int k = 0; k <= TP; k++) begin
      xq  = longint'((64'(k) << 35) / 64'(TP)) - (longint'(1) << 34);
      mag = (xq < 0) ? -xq : xq;
      // exp(-mag) in Q0.31: taylor series on mag/16, then squared four times
      arg    = mag >> 4;
      series = longint'(1) << 31;
      term   = 64'd1 << 31;
      for (int n = 1; n <= 14; n++) begin
        term = ((term * arg) >> 31) / 64'(n);
        if (n % 2 == 1) begin
          series = series - longint'(term);
        end else begin
          series = series + longint'(term);
        end
      end
      e = series;
      for (int n = 0; n < 4; n++) begin
        e = (e * e + (64'd1 << 30)) >> 31;
      end
      den = (64'd1 << 31) + e;
      num = (xq >= 0) ? (64'd1 << 31) : e;
      sigmoid_samples[k] = ((num << 30) + den / 2) / den;
      if (k > 0 && sigmoid_samples[k] < sigmoid_samples[k-1]) begin
        sigmoid_samples[k] = sigmoid_samples[k-1];
      end
    end
  end

  // interpolated sigmoid of z (sample format), Q0.30, clamped outside [-8,8)
  function automatic logic [63:0] sigmoid_q30(input longint z);
    longint      off;
    logic [63:0] pos, idx, frac_part, lo, hi;
    off = z + (longint'(8) << FRAC);
    if (off < 0) return sigmoid_samples[0];
    if (off >= (longint'(16) << FRAC)) return sigmoid_samples[TP];
    pos       = off;
    pos       = pos * 64'(TP);
    idx       = pos >> (FRAC + 4);
    frac_part = pos & ((64'd1 << (FRAC + 4)) - 1);
    if (idx >= 64'(TP)) return sigmoid_samples[TP];
    lo = sigmoid_samples[idx];
    hi = sigmoid_samples[idx + 1];
    return lo + (((hi - lo) * frac_part) >> (FRAC + 4));
  endfunction

  // Q0.30 to sample format, round half up
  function automatic longint q30_round(input logic [63:0] v);
    return longint'((v + (64'd1 << (29 - FRAC))) >> (30 - FRAC));
  endfunction

  // activation result for one element under the given mode and slope
  function automatic logic signed [DW-1:0] activation_of(input logic signed [DW-1:0] x,
                                                         input logic [MODE_W-1:0] md,
                                                         input logic [SLOPE_W-1:0] alpha);
    longint      xv, res, one, t;
    logic [63:0] s, m;
    xv  = x;
    one = longint'(1) << FRAC;
    res = 0;
    case (md)
      MODE_RELU: begin
        res = (xv > 0) ? xv : 0;
      end
      MODE_RELU_DERIV: begin
        res = (xv > 0) ? one : 0;
      end
      MODE_SIGMOID: begin
        res = q30_round(sigmoid_q30(xv));
      end
      MODE_SIGMOID_DERIV: begin
        s   = sigmoid_q30(xv);
        res = q30_round((s * (Q30_ONE - s)) >> 30);
      end
      MODE_TANH: begin
        s   = sigmoid_q30(2 * xv);
        res = q30_round(2 * s) - one;
      end
      MODE_TANH_DERIV: begin
        s = sigmoid_q30(2 * xv);
        t = longint'(2 * s) - longint'(Q30_ONE);
        m = (t < 0) ? -t : t;
        m = (m * m) >> 30;
        if (m > Q30_ONE) m = Q30_ONE;
        res = q30_round(Q30_ONE - m);
      end
      MODE_LEAKY: begin
        if (xv > 0) begin
          res = xv;
        end else begin
          // magnitude of alpha*x rounded half up, then negated
          m   = -xv;
          m   = (m * 64'(alpha) + (64'd1 << 15)) >> 16;
          res = -longint'(m);
        end
      end
      default: begin
        // leaky derivative: alpha brought from Q0.16 to the sample format
        if (xv > 0) begin
          res = one;
        end else begin
          res = longint'((64'(alpha) + (64'd1 << (15 - FRAC))) >> (16 - FRAC));
        end
      end
    endcase
    if (res > SAT_MAX) res = SAT_MAX;
    if (res < SAT_MIN) res = SAT_MIN;
    return DW'(res);
  endfunction

  // track registers, queue predictions on input transfers, check output transfers
  always @(posedge clk) begin
    if (rst) begin
      active_mode  <= MODE_RESET;
      active_slope <= LEAK_SLOPE_RESET;
      expected_results.delete();
      open_count   <= 0;
    end else begin
      if (cfg_write) begin
        if (cfg_index == REG_MODE) begin
          active_mode <= cfg_data[MODE_W-1:0];
        end else if (cfg_index == REG_LEAK_SLOPE) begin
          active_slope <= cfg_data[SLOPE_W-1:0];
        end
      end
      if (sample_valid && !sample_stall) begin
        expected_results.push_back('{value: activation_of(sample_in, active_mode, active_slope),
                                     is_last: last_in});
      end
      if (result_valid && !result_stall) begin
        if (expected_results.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected transfer, expected none, got sample_out %0d last_out %0b",
                   $time, sample_out, last_out);
        end else begin
          want = expected_results.pop_front();
          if (sample_out !== want.value) begin
            mismatches++;
            $display("%0t: sample_out expected %0d, got %0d", $time,
                     $signed(want.value), sample_out);
          end
          if (last_out !== want.is_last) begin
            mismatches++;
            $display("%0t: last_out expected %0b, got %0b", $time, want.is_last, last_out);
          end
        end
      end
      open_count <= expected_results.size();
    end
  end

endmodule

// ===== tb/testbench.sv =====
// Top of the activation unit testbench: clock, reset, stimulus and verdict
`timescale 1ns / 1ps

module testbench;
  import afu_pkg::*;

  localparam int DW           = DATA_WIDTH_DEFAULT;
  localparam int PIPE_LATENCY = 7;
  localparam int HOLD_CYCLES  = 100;
  localparam int CYCLE_LIMIT  = 100000;

  logic                   clk          = 1'b0;
  logic                   rst          = 1'b1;
  logic                   cfg_write    = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index    = '0;
  logic [CFG_DATA_W-1:0]  cfg_data     = '0;
  logic                   sample_valid = 1'b0;
  logic                   sample_stall;
  logic signed [DW-1:0]   sample_in    = '0;
  logic                   last_in      = 1'b0;
  logic                   result_valid;
  logic                   result_stall = 1'b0;
  logic signed [DW-1:0]   sample_out;
  logic                   last_out;

  int mismatches;
  int open_count;
  int cycle_count   = 0;
  int hold_requests = 0;
  int holds_done    = 0;
  int hold_left     = 0;
  bit sender_gaps   = 1'b1;
  bit receiver_gaps = 1'b1;

  logic [MODE_W-1:0] all_modes [8] = '{MODE_RELU, MODE_RELU_DERIV, MODE_SIGMOID,
                                       MODE_SIGMOID_DERIV, MODE_TANH, MODE_TANH_DERIV,
                                       MODE_LEAKY, MODE_LEAKY_DERIV};

  activation_function_unit_top dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample_in    (sample_in),
    .last_in      (last_in),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .sample_out   (sample_out),
    .last_out     (last_out)
  );

  afu_result_checker result_check (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample_in    (sample_in),
    .last_in      (last_in),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .sample_out   (sample_out),
    .last_out     (last_out),
    .mismatches   (mismatches),
    .open_count   (open_count)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // receiver: random stalls, plus long hold-offs on request
  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
      hold_left    <= 0;
    end else if (holds_done != hold_requests) begin
      holds_done   <= holds_done + 1;
      hold_left    <= HOLD_CYCLES;
      result_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left    <= hold_left - 1;
      result_stall <= 1'b1;
    end else begin
      result_stall <= receiver_gaps && ($urandom_range(99) < 35);
    end
  end

  // offer one element, with random idle cycles first, and wait for its transfer
  task automatic offer_sample(input logic signed [DW-1:0] x, input logic tag);
    while (sender_gaps && $urandom_range(99) < 35) begin
      sample_valid <= 1'b0;
      @(posedge clk);
    end
    sample_valid <= 1'b1;
    sample_in    <= x;
    last_in      <= tag;
    @(posedge clk);
    while (sample_stall) @(posedge clk);
  endtask

  // stop offering and wait until every predicted result has come out
  task automatic drain_pipeline();
    sample_valid <= 1'b0;
    @(posedge clk);
    while (open_count != 0) @(posedge clk);
    repeat (PIPE_LATENCY + 3) @(posedge clk);
  endtask

  // write both registers; unused high bits of the mode write carry noise
  task automatic load_config(input logic [MODE_W-1:0] md, input logic [SLOPE_W-1:0] alpha);
    cfg_write <= 1'b1;
    cfg_index <= REG_MODE;
    cfg_data  <= (CFG_DATA_W'($urandom) << MODE_W) | CFG_DATA_W'(md);
    @(posedge clk);
    cfg_index <= REG_LEAK_SLOPE;
    cfg_data  <= alpha;
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  // stimulus
  initial begin
    logic signed [DW-1:0] x;
    logic [MODE_W-1:0]    md;
    logic [SLOPE_W-1:0]   alpha;
    int                   n_items;

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: extremes and the corner of each mode, first mode on reset values
    for (int i = 0; i < 8; i++) begin
      if (i != 0) begin
        drain_pipeline();
        load_config(all_modes[i], (i >= 6) ? 16'hFFFF : LEAK_SLOPE_RESET);
      end
      offer_sample(16'sh8000, 1'b0);
      offer_sample(16'sh7FFF, 1'b1);
      case (all_modes[i])
        MODE_RELU:          x = 16'sd0;
        MODE_RELU_DERIV:    x = 16'sd1;
        MODE_SIGMOID:       x = -16'sd1;
        MODE_SIGMOID_DERIV: x = 16'sd0;
        // doubled argument lands exactly on the top of the table
        MODE_TANH:          x = 16'sd16384;
        // doubled argument falls below the table
        MODE_TANH_DERIV:    x = -16'sd16385;
        // smallest negative with the largest slope rounds to -1
        MODE_LEAKY:         x = -16'sd1;
        default:            x = 16'sd0;
      endcase
      offer_sample(x, 1'b0);
    end

    // random phases over modes and slopes
    for (int p = 0; p < 16; p++) begin
      md = (p < 8) ? all_modes[p] : all_modes[$urandom_range(7)];
      case (p % 4)
        0:       alpha = '0;
        1:       alpha = '1;
        2:       alpha = LEAK_SLOPE_RESET;
        default: alpha = SLOPE_W'($urandom);
      endcase
      drain_pipeline();
      load_config(md, alpha);
      // two phases run without idling and with a long receiver hold-off
      sender_gaps = (p != 0) && (p != 9);
      receiver_gaps <= sender_gaps;
      if (!sender_gaps) hold_requests <= hold_requests + 1;
      n_items = (p == 0) ? 200 : 95;
      for (int n = 0; n < n_items; n++) begin
        case ($urandom_range(9))
          0, 1, 2, 3, 4: x = DW'($urandom);
          5, 6, 7:       x = DW'($urandom_range(32767) - 16384);
          8:             x = DW'($urandom_range(128) - 64);
          default: begin
            case ($urandom_range(6))
              0:       x = 16'sh8000;
              1:       x = 16'sh7FFF;
              2:       x = 16'sd0;
              3:       x = -16'sd1;
              4:       x = 16'sd1;
              5:       x = 16'sd16384;
              default: x = -16'sd16384;
            endcase
          end
        endcase
        offer_sample(x, $urandom_range(7) == 0);
      end
    end

    drain_pipeline();
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
